[hw/rtl/box_blur_window_mean_core_assert.svh]
// Assertion helpers used by the checker file bbwm_chk.sv.
`ifndef BOX_BLUR_WINDOW_MEAN_CORE_ASSERT_SVH
`define BOX_BLUR_WINDOW_MEAN_CORE_ASSERT_SVH

// Plain property, sampled on the rising edge and disabled in reset.
`define BBWM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A signal keeps its value in the cycle after a condition holds.
`define BBWM_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  `BBWM_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig), msg)

`endif

[hw/rtl/bbwm_pkg.sv]
package bbwm_pkg;

  localparam int CfgAddrW = 4;
  localparam int ColSumW  = 11;
  localparam int WinSumW  = 14;

  typedef enum logic [1:0] {
    REG_IMAGE_COLS = 2'd0,
    REG_IMAGE_ROWS = 2'd1,
    REG_WIN_W      = 2'd2,
    REG_WIN_H      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] image_cols;
    logic [11:0] image_rows;
    logic [3:0]  win_w;
    logic [3:0]  win_h;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic lrd;
    logic lacc;
    logic wr;
    logic wrd;
    logic wacc;
    logic dinit;
    logic dstep;
    logic oload;
  } dp_cmd_t;

  typedef struct packed {
    logic more_lines;
    logic has_result;
    logic more_cols;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

[hw/rtl/bbwm_pix_if.sv]
interface bbwm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

[hw/rtl/bbwm_res_if.sv]
interface bbwm_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mean_value;
  logic [9:0]  centre_col;
  logic [11:0] centre_row;

  modport source (output valid, mean_value, centre_col, centre_row, input ready);
  modport sink (input valid, mean_value, centre_col, centre_row, output ready);
endinterface

[hw/rtl/box_blur_window_mean_core.sv]
// Channel  Dir  Word                                       Handshake
// pix_in   in   pixel[7:0], frame_start                    valid/ready
// res_out  out  mean_value[7:0], centre_col[9:0],          valid/ready
//               centre_row[11:0]
// apb      in   image_cols, image_rows, win_w, win_h       psel/penable, pready high
//
// One pixel is handled at a time; the work per pixel, shorter for a pixel without a
// result, is set by the single-port line and column-sum memories (read then add per
// line or column) and the one-bit-per-cycle divider.
// A finished word sits in the output register, so the next pixel is taken while it
// waits. Reset clears the position counters and the output valid; the memories
// need no clearing pass.
module box_blur_window_mean_core
  import bbwm_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_WIN  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bbwm_pix_if.sink            pix_in,
  bbwm_res_if.source          res_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  bbwm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_in.valid),
    .in_ready_o (pix_in.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbwm_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_WIN  (MAX_WIN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pixel_i       (pix_in.pixel),
    .frame_start_i (pix_in.frame_start),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (res_out.ready),
    .out_valid_o   (res_out.valid),
    .mean_value_o  (res_out.mean_value),
    .centre_col_o  (res_out.centre_col),
    .centre_row_o  (res_out.centre_row)
  );

endmodule

[hw/rtl/bbwm_regs.sv]
module bbwm_regs
  import bbwm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_IMAGE_COLS: cfg_d.image_cols = pwdata[10:0];
        REG_IMAGE_ROWS: cfg_d.image_rows = pwdata[11:0];
        REG_WIN_W:      cfg_d.win_w = pwdata[3:0];
        REG_WIN_H:      cfg_d.win_h = pwdata[3:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_COLS: prdata = {21'd0, cfg_q.image_cols};
      REG_IMAGE_ROWS: prdata = {20'd0, cfg_q.image_rows};
      REG_WIN_W:      prdata = {28'd0, cfg_q.win_w};
      REG_WIN_H:      prdata = {28'd0, cfg_q.win_h};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{image_cols: 11'd512, image_rows: 12'd512, win_w: 4'd3, win_h: 4'd3};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hw/rtl/bbwm_ctrl.sv]
module bbwm_ctrl
  import bbwm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LRD, S_LACC, S_WR, S_WRD, S_WACC, S_DINIT, S_DSTEP, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LRD;
        end
      end
      S_LRD: begin
        if (sts_i.more_lines) begin
          cmd_o.lrd = 1'b1;
          state_d   = S_LACC;
        end else begin
          state_d = S_WR;
        end
      end
      S_LACC: begin
        cmd_o.lacc = 1'b1;
        state_d    = S_LRD;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.has_result ? S_WRD : S_IDLE;
      end
      S_WRD: begin
        if (sts_i.more_cols) begin
          cmd_o.wrd = 1'b1;
          state_d   = S_WACC;
        end else begin
          state_d = S_DINIT;
        end
      end
      S_WACC: begin
        cmd_o.wacc = 1'b1;
        state_d    = S_WRD;
      end
      S_DINIT: begin
        cmd_o.dinit = 1'b1;
        state_d     = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.dstep = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.oload = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/bbwm_dp.sv]
module bbwm_dp
  import bbwm_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_WIN  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic [7:0]  pixel_i,
  input  logic        frame_start_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  mean_value_o,
  output logic [9:0]  centre_col_o,
  output logic [11:0] centre_row_o
);

  localparam int Lines = MAX_WIN - 1;
  localparam int SW    = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int WW    = $clog2(MAX_WIN + 1);
  localparam int AW    = $clog2(Lines * MAX_COLS);
  localparam int RW    = 13;
  localparam int NW    = $clog2(MAX_WIN * MAX_WIN + 1);
  localparam int DW    = NW + 1;
  localparam int DSW   = DW + 1;
  localparam int DVW   = $clog2(2 * (2 ** WinSumW - 1) + MAX_WIN * MAX_WIN + 1);
  localparam int DCW   = $clog2(DVW);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(Lines - 1)) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
    return (s == '0) ? SW'(Lines - 1) : s - SW'(1);
  endfunction

  logic [7:0]         line_mem [Lines*MAX_COLS];
  logic [ColSumW-1:0] col_mem  [MAX_COLS];

  // Position of the next pixel.
  logic [CW-1:0]  col_cnt_q;
  logic [11:0]    row_cnt_q;
  logic [SW-1:0]  slot_cnt_q;

  logic [CW-1:0]      col_q, wk_q;
  logic [11:0]        row_q;
  logic [SW-1:0]      slot_q, rp_q;
  logic [7:0]         pix_q, line_rd_q;
  logic [ColSumW-1:0] acc_q, col_rd_q;
  logic [WinSumW-1:0] ws_q;
  logic [WW-1:0]      k_q, depth_q;
  logic [9:0]         cc_q, out_cc_q;
  logic [11:0]        cr_q, out_cr_q;
  logic [7:0]         out_mean_q;
  logic [DSW-1:0]     rem_q;
  logic [DVW-1:0]     quo_q;
  logic [DW-1:0]      dsr_q;
  logic [DCW-1:0]     dcnt_q;
  logic               out_valid_q;

  logic [CCW-1:0] cols, c0, nc;
  logic [11:0]    rows;
  logic [WW-1:0]  w, h, depth;
  logic [RW-1:0]  r0, nr;
  logic [SW-1:0]  s0, ns;
  logic [NW-1:0]  n;
  logic [31:0]    left32, top32;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [DSW-1:0] r_sh;
  logic           ge;

  always_comb begin
    if (cfg_i.image_cols == '0) cols = CCW'(1);
    else if (32'(cfg_i.image_cols) > MAX_COLS) cols = CCW'(MAX_COLS);
    else cols = CCW'(cfg_i.image_cols);
    rows = (cfg_i.image_rows == '0) ? 12'd1 : cfg_i.image_rows;
    if (cfg_i.win_w == '0) w = WW'(1);
    else if (32'(cfg_i.win_w) > MAX_WIN) w = WW'(MAX_WIN);
    else w = WW'(cfg_i.win_w);
    if (cfg_i.win_h == '0) h = WW'(1);
    else if (32'(cfg_i.win_h) > MAX_WIN) h = WW'(MAX_WIN);
    else h = WW'(cfg_i.win_h);
  end

  // Placement of the incoming pixel and the position that follows it.
  always_comb begin
    c0 = frame_start_i ? '0 : CCW'(col_cnt_q);
    r0 = frame_start_i ? '0 : {1'b0, row_cnt_q};
    s0 = frame_start_i ? '0 : slot_cnt_q;
    if (c0 >= cols) begin
      c0 = '0;
      r0 = r0 + RW'(1);
      s0 = slot_inc(s0);
    end
    if (r0 >= RW'(rows)) begin
      r0 = '0;
      s0 = '0;
    end
    nc = c0 + CCW'(1);
    nr = r0;
    ns = s0;
    if (nc >= cols) begin
      nc = '0;
      nr = r0 + RW'(1);
      ns = slot_inc(s0);
      if (nr >= RW'(rows)) begin
        nr = '0;
        ns = '0;
      end
    end
    if (32'(h) - 32'd1 > 32'(r0)) depth = WW'(r0);
    else depth = h - WW'(1);
  end

  assign n       = NW'(32'(w) * 32'(h));
  assign left32  = 32'(col_q) + 32'd1 - 32'(w);
  assign top32   = 32'(row_q) + 32'd1 - 32'(h);
  assign rd_addr = AW'(32'(rp_q) * MAX_COLS + 32'(col_q));
  assign wr_addr = AW'(32'(slot_q) * MAX_COLS + 32'(col_q));
  assign r_sh    = {rem_q[DSW-2:0], quo_q[DVW-1]};
  assign ge      = r_sh >= DSW'(dsr_q);

  assign sts_o.more_lines = k_q <= depth_q;
  assign sts_o.has_result = (32'(col_q) + 32'd1 >= 32'(w)) && (32'(row_q) + 32'd1 >= 32'(h));
  assign sts_o.more_cols  = wk_q < col_q;
  assign sts_o.div_last   = dcnt_q == DCW'(DVW - 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign mean_value_o = out_mean_q;
  assign centre_col_o = out_cc_q;
  assign centre_row_o = out_cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      slot_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        col_cnt_q  <= CW'(nc);
        row_cnt_q  <= nr[11:0];
        slot_cnt_q <= ns;
      end
      if (cmd_i.oload) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q   <= CW'(c0);
      row_q   <= r0[11:0];
      slot_q  <= s0;
      rp_q    <= slot_dec(s0);
      pix_q   <= pixel_i;
      acc_q   <= ColSumW'(pixel_i);
      k_q     <= WW'(1);
      depth_q <= depth;
    end
    if (cmd_i.lrd) begin
      line_rd_q <= line_mem[rd_addr];
    end
    if (cmd_i.lacc) begin
      acc_q <= acc_q + ColSumW'(line_rd_q);
      k_q   <= k_q + WW'(1);
      rp_q  <= slot_dec(rp_q);
    end
    if (cmd_i.wr) begin
      col_mem[col_q]    <= acc_q;
      line_mem[wr_addr] <= pix_q;
      ws_q              <= WinSumW'(acc_q);
      wk_q              <= CW'(left32);
      cc_q              <= 10'(left32 + (32'(w) >> 1));
      cr_q              <= 12'(top32 + (32'(h) >> 1));
    end
    if (cmd_i.wrd) begin
      col_rd_q <= col_mem[wk_q];
    end
    if (cmd_i.wacc) begin
      ws_q <= ws_q + WinSumW'(col_rd_q);
      wk_q <= wk_q + CW'(1);
    end
    // Restoring division of (2*sum + n) by 2*n, one quotient bit per cycle.
    if (cmd_i.dinit) begin
      quo_q  <= DVW'({ws_q, 1'b0}) + DVW'(n);
      rem_q  <= '0;
      dsr_q  <= {n, 1'b0};
      dcnt_q <= '0;
    end
    if (cmd_i.dstep) begin
      rem_q  <= ge ? r_sh - DSW'(dsr_q) : r_sh;
      quo_q  <= {quo_q[DVW-2:0], ge};
      dcnt_q <= dcnt_q + DCW'(1);
    end
    if (cmd_i.oload) begin
      out_mean_q <= quo_q[7:0];
      out_cc_q   <= cc_q;
      out_cr_q   <= cr_q;
    end
  end

endmodule

[hw/rtl/bbwm_chk.sv]
`include "box_blur_window_mean_core_assert.svh"

module bbwm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  mean_value_i,
  input logic [9:0]  centre_col_i,
  input logic [11:0] centre_row_i
);

  // A stalled result word keeps its valid and its contents.
  `BBWM_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, {out_valid_i, mean_value_i, centre_col_i, centre_row_i}, "result word changed while stalled")

  // Only one pixel is in flight, so ready drops right after an accept.
  `BBWM_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "pixel accepted while busy")

  // A result needs work after its pixel is taken, so valid does not rise at once.
  `BBWM_ASSERT(a_no_instant, clk_i, rst_ni, in_valid_i && in_ready_i |=> !$rose(out_valid_i), "result appeared too early")

  // The window centre never lies beyond the last possible row.
  `BBWM_ASSERT(a_row_range, clk_i, rst_ni, out_valid_i |-> centre_row_i <= 12'd4094, "centre row out of range")

endmodule

bind box_blur_window_mean_core bbwm_chk u_bbwm_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_in.valid),
  .in_ready_i   (pix_in.ready),
  .out_valid_i  (res_out.valid),
  .out_ready_i  (res_out.ready),
  .mean_value_i (res_out.mean_value),
  .centre_col_i (res_out.centre_col),
  .centre_row_i (res_out.centre_row)
);

[dv/bbwm_window_checker.sv]
module bbwm_window_checker
  import bbwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bbwm_pix_if         pix,
  bbwm_res_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cols  = 1024;
  localparam int Win   = 8;
  localparam int Lines = Win - 1;

  typedef struct {
    logic [7:0]  mean_value;
    logic [9:0]  centre_col;
    logic [11:0] centre_row;
  } blur_res_t;

  logic [7:0]  line_mem [Lines*Cols];
  logic [10:0] col_sum  [Cols];
  logic [13:0] win_sum;
  int unsigned next_col, next_row;
  logic [10:0] cfg_cols;
  logic [11:0] cfg_rows;
  logic [3:0]  cfg_w, cfg_h;
  blur_res_t   blur_q[$];

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  // Places one pixel and, when a full window ends on it, queues the mean.
  task automatic blur_pixel(logic [7:0] px, logic fs);
    int unsigned cols, rows, w, h, col, row, depth, csum, s, n, left, top;
    blur_res_t r;
    cols = clip(cfg_cols, Cols);
    rows = clip(cfg_rows, 4095);
    w = clip(cfg_w, Win);
    h = clip(cfg_h, Win);
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    if (next_col >= cols) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= rows) next_row = 0;
    col = next_col;
    row = next_row;
    depth = (h - 1 > row) ? row : h - 1;
    csum = px;
    for (int unsigned k = 1; k <= depth; k++) csum += line_mem[((row - k) % Lines) * Cols + col];
    col_sum[col] = csum[10:0];
    line_mem[(row % Lines) * Cols + col] = px;
    if (col + 1 >= w && row + 1 >= h) begin
      left = col + 1 - w;
      top = row + 1 - h;
      s = 0;
      for (int unsigned k = left; k <= col; k++) s += col_sum[k];
      win_sum = s[13:0];
      n = w * h;
      r.mean_value = 8'((2 * win_sum + n) / (2 * n));
      r.centre_col = 10'(left + w / 2);
      r.centre_row = 12'(top + h / 2);
      blur_q.push_back(r);
    end
    next_col = col + 1;
    if (next_col >= cols) begin
      next_col = 0;
      next_row = row + 1;
      if (next_row >= rows) next_row = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blur_res_t e;
    if (!rst_ni) begin
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (col_sum[i]) col_sum[i] = '0;
      win_sum = '0;
      next_col = 0;
      next_row = 0;
      cfg_cols = 11'd512;
      cfg_rows = 12'd512;
      cfg_w = 4'd3;
      cfg_h = 4'd3;
      blur_q.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_IMAGE_COLS: cfg_cols = pwdata[10:0];
          REG_IMAGE_ROWS: cfg_rows = pwdata[11:0];
          REG_WIN_W:      cfg_w = pwdata[3:0];
          REG_WIN_H:      cfg_h = pwdata[3:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) blur_pixel(pix.pixel, pix.frame_start);
      if (res.valid && res.ready) begin
        results_o++;
        if (blur_q.size() == 0) begin
          report("unexpected word, mean", res.mean_value, -1);
        end else begin
          e = blur_q.pop_front();
          if (res.mean_value !== e.mean_value) report("mean", res.mean_value, e.mean_value);
          if (res.centre_col !== e.centre_col) report("centre_col", res.centre_col, e.centre_col);
          if (res.centre_row !== e.centre_row) report("centre_row", res.centre_row, e.centre_row);
        end
      end
    end
    pending_o = blur_q.size();
  end
endmodule

[dv/tb_box_blur_window_mean_core.sv]
module tb_box_blur_window_mean_core;
  import bbwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int Drain      = 80;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending, results;
  int          sent, phases, quiet;
  int unsigned frame_min;
  bit          calm, hold_req;

  bbwm_pix_if pix_if ();
  bbwm_res_if res_if ();

  box_blur_window_mean_core DUT (
    .clk_i, .rst_ni, .pix_in(pix_if), .res_out(res_if),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bbwm_window_checker u_checker (
    .clk_i, .rst_ni, .pix(pix_if), .res(res_if),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    res_if.ready <= 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        res_if.ready <= 0;
        repeat (400) @(posedge clk_i);
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_cols(int unsigned v);
    v = v & 32'h7FF;
    if (v == 0) return 1;
    return (v > 1024) ? 1024 : v;
  endfunction

  task automatic cfg_write(reg_idx_e idx, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
  endtask

  task automatic send_pixel(logic [7:0] px, logic fs);
    if (!calm && $urandom_range(99) < 23) begin
      pix_if.valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    pix_if.valid <= 1;
    pix_if.pixel <= px;
    pix_if.frame_start <= fs;
    do @(posedge clk_i); while (!pix_if.ready);
    sent++;
  endtask

  function automatic logic [7:0] rand_pixel();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return 8'h00;
    if (p < 20) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Waits until the block has drained, then streams one configuration.
  task automatic run_blur(int unsigned c, int unsigned r, int unsigned w, int unsigned h,
                          int n, bit noise, int fixed);
    bit restart;
    logic fs;
    wait (pending == 0);
    repeat (Drain) @(posedge clk_i);
    cfg_write(REG_IMAGE_COLS, c);
    cfg_write(REG_IMAGE_ROWS, r);
    cfg_write(REG_WIN_W, w);
    cfg_write(REG_WIN_H, h);
    // Keeping the running frame is safe only while no earlier line is narrower.
    restart = (eff_cols(c) > frame_min) || ($urandom_range(1) == 1);
    if (!restart && eff_cols(c) < frame_min) frame_min = eff_cols(c);
    phases++;
    for (int i = 0; i < n; i++) begin
      fs = (i == 0 && restart) || (noise && $urandom_range(99) < 3);
      if (fs) frame_min = eff_cols(c);
      send_pixel((fixed >= 0) ? 8'(fixed) : rand_pixel(), fs);
    end
    pix_if.valid <= 0;
  endtask

  initial begin
    int unsigned c, r;
    rst_ni = 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    pix_if.valid <= 0;
    pix_if.pixel <= '0;
    pix_if.frame_start <= 0;
    frame_min = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: full-scale windows, zero and oversized registers, window above image.
    run_blur(3, 3, 3, 3, 9, 0, 255);
    run_blur(3, 3, 3, 3, 9, 0, 0);
    run_blur(0, 0, 0, 0, 3, 0, -1);
    run_blur(2047, 4095, 15, 15, 3, 0, -1);
    run_blur(4, 4, 8, 8, 6, 0, -1);

    hold_req = 1;
    run_blur(6, 5, 2, 2, 60, 0, -1);
    run_blur(1024, 3, 3, 1, 1030, 0, -1);
    while (sent < 1900) begin
      c = ($urandom_range(9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      r = $urandom_range(1, 10);
      calm = (phases == 12);
      run_blur(c, r, $urandom_range(0, 9), $urandom_range(0, 9),
               $urandom_range(c * r, 2 * c * r + 4) % 150 + 1, $urandom_range(3) == 0, -1);
      calm = 0;
    end

    wait (pending == 0);
    repeat (Drain) @(posedge clk_i);
    $display("Streamed %0d pixels over %0d window settings; %0d means checked.",
             sent, phases, results);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
